[hdl/sphere_collision_response_top_macros.svh]
// Assertion macros shared by the sphere collision response design
`ifndef SPHERE_COLLISION_RESPONSE_TOP_MACROS_SVH
`define SPHERE_COLLISION_RESPONSE_TOP_MACROS_SVH

// Implication checked at every rising clock edge outside reset
`define SCR_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("scr: implication check failed");

// Condition that must never be seen outside reset
`define SCR_ASSERT_NEVER(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error("scr: forbidden condition seen");

`endif

[hdl/scr_pkg.sv]
// Package: widths, transaction types and arithmetic helpers of the collision pipeline
package scr_pkg;

   // vector component and field widths
   localparam int CW      = 20;
   localparam int VEC_W   = 60;
   localparam int RAD_W   = 20;
   localparam int BNC_W   = 10;

   // center difference and squared distance
   localparam int D_W     = CW + 1;
   localparam int SQ_W    = 2 * D_W;
   localparam int DIST2_W = SQ_W + 2;
   localparam int RSUM_W  = RAD_W + 1;
   localparam int RSQ_W   = 2 * RSUM_W;
   localparam int CMP_W   = (DIST2_W > RSQ_W) ? DIST2_W : RSQ_W;

   // square root: radicand carries 16 extra fraction bits
   localparam int FRAC_EXT = 16;
   localparam int X_W      = RSQ_W + FRAC_EXT;
   localparam int ROOT_W   = X_W / 2;
   localparam int ISQ_STAGES = ROOT_W + 1;

   // normal division
   localparam int NQ_W      = 17;
   localparam int DIV_W     = ROOT_W + NQ_W;
   localparam int NUM_SHIFT = 24;
   localparam int DIV_STAGES = NQ_W + 2;
   localparam int N_W       = 18;
   localparam int NORM_ONE  = 65536;

   // penetration and response arithmetic
   localparam int PEN_SHIFT = 8;
   localparam int PEN_W     = RSUM_W + PEN_SHIFT;
   localparam int F_W       = BNC_W + 1;
   localparam int F_BASE    = 256;
   localparam int NF_W      = N_W + F_W + 1;
   localparam int PROD_W    = N_W + PEN_W + 1;
   localparam int DISP_W    = PROD_W - 23;
   localparam int VP_W      = CW + N_W;
   localparam int DOT_W     = VP_W + 2;
   localparam int VN_W      = DOT_W - 9;
   localparam int CORR_W    = NF_W + VN_W;
   localparam int RESP_STAGES = 4;

   // rounding shifts
   localparam logic [5:0] VN_SHIFT   = 6'd10;
   localparam logic [5:0] DISP_FULL  = 6'd24;
   localparam logic [5:0] DISP_HALF  = 6'd25;
   localparam logic [5:0] CORR_SHIFT = 6'd30;

   // register count from the input register to the result register
   localparam int LATENCY = 3 + ISQ_STAGES + DIV_STAGES + RESP_STAGES;

   typedef struct packed {
      logic [VEC_W-1:0] pos_a;
      logic [VEC_W-1:0] pos_b;
      logic [VEC_W-1:0] vel_a;
      logic [VEC_W-1:0] vel_b;
      logic [RAD_W-1:0] radius_a;
      logic [RAD_W-1:0] radius_b;
      logic [BNC_W-1:0] bounce_a;
      logic [BNC_W-1:0] bounce_b;
      logic             static_a;
      logic             static_b;
      logic             enabled_a;
      logic             enabled_b;
   } req_type;

   typedef struct packed {
      logic [VEC_W-1:0] new_pos_a;
      logic [VEC_W-1:0] new_pos_b;
      logic [VEC_W-1:0] new_vel_a;
      logic [VEC_W-1:0] new_vel_b;
      logic             collided;
      logic             ground_a;
      logic             ground_b;
   } rsp_type;

   // context carried down the pipeline, filled in as stages go by
   typedef struct packed {
      req_type               item;
      logic [2:0][D_W-1:0]   d;
      logic [RSUM_W-1:0]     rsum;
      logic                  hit;
      logic [ROOT_W-1:0]     dist_len;
      logic [PEN_W-1:0]      pen;
      logic                  zero;
   } ctx_type;

   typedef logic [2:0][N_W-1:0] norm_type;

   // signed component i of a packed vector
   function automatic logic signed [CW-1:0] comp_get(input logic [VEC_W-1:0] v, input int i);
      comp_get = $signed(v[i*CW +: CW]);
   endfunction

   // clamp to the signed component range
   function automatic logic signed [CW-1:0] sat_comp(input logic signed [63:0] v);
      logic signed [63:0] cmax;
      logic signed [63:0] cmin;
      cmax = (64'sd1 <<< (CW - 1)) - 64'sd1;
      cmin = -cmax - 64'sd1;
      if (v > cmax) begin
         sat_comp = cmax[CW-1:0];
      end else if (v < cmin) begin
         sat_comp = cmin[CW-1:0];
      end else begin
         sat_comp = v[CW-1:0];
      end
   endfunction

   // shift right, rounding half away from zero
   function automatic logic signed [63:0] shr_round(input logic signed [63:0] v,
                                                    input logic [5:0] s);
      logic [63:0] mag;
      logic [63:0] half;
      logic [63:0] r;
      half = 64'd1 << (s - 6'd1);
      mag  = v[63] ? 64'(-v) : 64'(v);
      r    = (mag + half) >> s;
      shr_round = v[63] ? -$signed(r) : $signed(r);
   endfunction

endpackage

[hdl/scr_isqrt.sv]
// Pipelined integer square root, one result bit per stage after the input stage
module scr_isqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [scr_pkg::X_W-1:0]       in_x,
   input  scr_pkg::ctx_type              in_ctx,
   output logic                          out_valid,
   output logic [scr_pkg::ROOT_W-1:0]    out_root,
   output scr_pkg::ctx_type              out_ctx
);

   logic                          valid_ff [scr_pkg::ISQ_STAGES];
   logic [scr_pkg::X_W-1:0]       rem_ff   [scr_pkg::ISQ_STAGES];
   logic [scr_pkg::X_W-1:0]       rem_in   [scr_pkg::ISQ_STAGES];
   logic [scr_pkg::ROOT_W-1:0]    root_ff  [scr_pkg::ISQ_STAGES];
   logic [scr_pkg::ROOT_W-1:0]    root_in  [scr_pkg::ISQ_STAGES];
   logic [scr_pkg::X_W:0]         trial    [scr_pkg::ISQ_STAGES];
   scr_pkg::ctx_type              ctx_ff   [scr_pkg::ISQ_STAGES];

   // stage k decides root bit ROOT_W-k; remainder tracks x - root^2
   always_comb begin
      rem_in[0]  = in_x;
      root_in[0] = '0;
      trial[0]   = '0;
      for (int k = 1; k < scr_pkg::ISQ_STAGES; k++) begin
         trial[k] = ({{(scr_pkg::X_W + 1 - scr_pkg::ROOT_W){1'b0}}, root_ff[k-1]}
                     << (scr_pkg::ISQ_STAGES - k))
                  + ((scr_pkg::X_W + 1)'(1) << (2 * (scr_pkg::ISQ_STAGES - 1 - k)));
         if ({1'b0, rem_ff[k-1]} >= trial[k]) begin
            rem_in[k]  = rem_ff[k-1] - trial[k][scr_pkg::X_W-1:0];
            root_in[k] = root_ff[k-1] | (scr_pkg::ROOT_W'(1) << (scr_pkg::ISQ_STAGES - 1 - k));
         end else begin
            rem_in[k]  = rem_ff[k-1];
            root_in[k] = root_ff[k-1];
         end
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < scr_pkg::ISQ_STAGES; k++) valid_ff[k] <= 1'b0;
      end else begin
         valid_ff[0] <= in_valid;
         for (int k = 1; k < scr_pkg::ISQ_STAGES; k++) valid_ff[k] <= valid_ff[k-1];
      end
   end

   // payload
   always_ff @(posedge clock) begin
      ctx_ff[0] <= in_ctx;
      for (int k = 1; k < scr_pkg::ISQ_STAGES; k++) ctx_ff[k] <= ctx_ff[k-1];
      for (int k = 0; k < scr_pkg::ISQ_STAGES; k++) begin
         rem_ff[k]  <= rem_in[k];
         root_ff[k] <= root_in[k];
      end
   end

   assign out_valid = valid_ff[scr_pkg::ISQ_STAGES-1];
   assign out_root  = root_ff[scr_pkg::ISQ_STAGES-1];
   assign out_ctx   = ctx_ff[scr_pkg::ISQ_STAGES-1];

endmodule

[hdl/scr_ndiv.sv]
// Unit normal: three pipelined restoring dividers plus penetration depth
module scr_ndiv (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  logic [scr_pkg::ROOT_W-1:0]  in_root,
   input  scr_pkg::ctx_type            in_ctx,
   output logic                        out_valid,
   output scr_pkg::ctx_type            out_ctx,
   output scr_pkg::norm_type           out_nrm
);

   logic                                     valid_ff [scr_pkg::DIV_STAGES];
   scr_pkg::ctx_type                         ctx_ff   [scr_pkg::DIV_STAGES];
   scr_pkg::ctx_type                         ctx0;
   logic [2:0][scr_pkg::DIV_W-1:0]           rem_ff   [scr_pkg::NQ_W+1];
   logic [2:0][scr_pkg::DIV_W-1:0]           rem_in   [scr_pkg::NQ_W+1];
   logic [2:0][scr_pkg::NQ_W-1:0]            q_ff     [scr_pkg::NQ_W+1];
   logic [2:0][scr_pkg::NQ_W-1:0]            q_in     [scr_pkg::NQ_W+1];
   logic [scr_pkg::DIV_W-1:0]                den_sh   [scr_pkg::NQ_W+1];
   logic signed [scr_pkg::D_W-1:0]           dd       [3];
   logic [scr_pkg::D_W-1:0]                  absd     [3];
   logic [scr_pkg::PEN_W-1:0]                rs8;
   logic [scr_pkg::NQ_W-1:0]                 qc       [3];
   logic [scr_pkg::N_W-1:0]                  qn       [3];
   scr_pkg::norm_type                        nrm_in;
   scr_pkg::norm_type                        nrm_ff;

   // stage 0: numerators, penetration, coincident-center flag
   always_comb begin
      ctx0          = in_ctx;
      ctx0.dist_len = in_root;
      ctx0.zero     = (in_root == '0);
      rs8           = {in_ctx.rsum, {scr_pkg::PEN_SHIFT{1'b0}}};
      ctx0.pen      = (rs8 >= in_root) ? rs8 - in_root : '0;
      den_sh[0]     = '0;
      for (int i = 0; i < 3; i++) begin
         dd[i]   = $signed(in_ctx.d[i]);
         absd[i] = dd[i][scr_pkg::D_W-1] ? scr_pkg::D_W'(-dd[i]) : scr_pkg::D_W'(dd[i]);
         rem_in[0][i] = (scr_pkg::DIV_W'(absd[i]) << scr_pkg::NUM_SHIFT)
                      + scr_pkg::DIV_W'(in_root >> 1);
         q_in[0][i]   = '0;
      end
      // stage k decides quotient bit NQ_W-k
      for (int k = 1; k <= scr_pkg::NQ_W; k++) begin
         den_sh[k] = scr_pkg::DIV_W'(ctx_ff[k-1].dist_len) << (scr_pkg::NQ_W - k);
         for (int i = 0; i < 3; i++) begin
            if (rem_ff[k-1][i] >= den_sh[k]) begin
               rem_in[k][i] = rem_ff[k-1][i] - den_sh[k];
               q_in[k][i]   = q_ff[k-1][i] | (scr_pkg::NQ_W'(1) << (scr_pkg::NQ_W - k));
            end else begin
               rem_in[k][i] = rem_ff[k-1][i];
               q_in[k][i]   = q_ff[k-1][i];
            end
         end
      end
   end

   // last stage: clamp, sign, default normal for coincident centers
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         qc[i] = (q_ff[scr_pkg::NQ_W][i] > scr_pkg::NQ_W'(scr_pkg::NORM_ONE))
               ? scr_pkg::NQ_W'(scr_pkg::NORM_ONE) : q_ff[scr_pkg::NQ_W][i];
         qn[i] = {1'b0, qc[i]};
         if (ctx_ff[scr_pkg::NQ_W].zero) begin
            nrm_in[i] = (i == 1) ? scr_pkg::N_W'(scr_pkg::NORM_ONE) : '0;
         end else if (ctx_ff[scr_pkg::NQ_W].d[i][scr_pkg::D_W-1]) begin
            nrm_in[i] = -qn[i];
         end else begin
            nrm_in[i] = qn[i];
         end
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < scr_pkg::DIV_STAGES; k++) valid_ff[k] <= 1'b0;
      end else begin
         valid_ff[0] <= in_valid;
         for (int k = 1; k < scr_pkg::DIV_STAGES; k++) valid_ff[k] <= valid_ff[k-1];
      end
   end

   // payload
   always_ff @(posedge clock) begin
      ctx_ff[0] <= ctx0;
      for (int k = 1; k < scr_pkg::DIV_STAGES; k++) ctx_ff[k] <= ctx_ff[k-1];
      for (int k = 0; k <= scr_pkg::NQ_W; k++) begin
         rem_ff[k] <= rem_in[k];
         q_ff[k]   <= q_in[k];
      end
      nrm_ff <= nrm_in;
   end

   assign out_valid = valid_ff[scr_pkg::DIV_STAGES-1];
   assign out_ctx   = ctx_ff[scr_pkg::DIV_STAGES-1];
   assign out_nrm   = nrm_ff;

endmodule

[hdl/scr_resp.sv]
// Separation and restitution stages, ending in the result register
module scr_resp (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  scr_pkg::ctx_type   in_ctx,
   input  scr_pkg::norm_type  in_nrm,
   output logic               out_valid,
   output scr_pkg::rsp_type   out_item
);

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   scr_pkg::ctx_type ctx1_ff, ctx2_ff, ctx3_ff;

   logic [scr_pkg::F_W-1:0]            fa, fb;
   logic signed [scr_pkg::N_W-1:0]     n         [3];
   logic signed [scr_pkg::PROD_W-1:0]  prod_in   [3];
   logic signed [scr_pkg::PROD_W-1:0]  prod_ff   [3];
   logic signed [scr_pkg::NF_W-1:0]    nfa_in    [3];
   logic signed [scr_pkg::NF_W-1:0]    nfb_in    [3];
   logic signed [scr_pkg::NF_W-1:0]    nfa1_ff   [3];
   logic signed [scr_pkg::NF_W-1:0]    nfb1_ff   [3];
   logic signed [scr_pkg::NF_W-1:0]    nfa2_ff   [3];
   logic signed [scr_pkg::NF_W-1:0]    nfb2_ff   [3];
   logic signed [scr_pkg::VP_W-1:0]    vpa_in    [3];
   logic signed [scr_pkg::VP_W-1:0]    vpb_in    [3];
   logic signed [scr_pkg::VP_W-1:0]    vpa_ff    [3];
   logic signed [scr_pkg::VP_W-1:0]    vpb_ff    [3];

   logic signed [scr_pkg::DOT_W-1:0]   dot_a, dot_b;
   logic signed [scr_pkg::VN_W-1:0]    vna_in, vnb_in, vna_ff, vnb_ff;
   logic signed [scr_pkg::DISP_W-1:0]  dispa_in  [3];
   logic signed [scr_pkg::DISP_W-1:0]  dispb_in  [3];
   logic signed [scr_pkg::DISP_W-1:0]  dispa_ff  [3];
   logic signed [scr_pkg::DISP_W-1:0]  dispb_ff  [3];

   logic [scr_pkg::VEC_W-1:0]          posa_in, posb_in, posa_ff, posb_ff;
   logic signed [scr_pkg::CORR_W-1:0]  corra_in  [3];
   logic signed [scr_pkg::CORR_W-1:0]  corrb_in  [3];
   logic signed [scr_pkg::CORR_W-1:0]  corra_ff  [3];
   logic signed [scr_pkg::CORR_W-1:0]  corrb_ff  [3];

   logic                               move_a2, move_b2, move_a3, move_b3;
   logic signed [scr_pkg::D_W-1:0]     dy;
   scr_pkg::rsp_type                   item_in, item_ff;

   // stage 1: products with the normal
   always_comb begin
      fa = scr_pkg::F_W'(scr_pkg::F_BASE) + scr_pkg::F_W'(in_ctx.item.bounce_a);
      fb = scr_pkg::F_W'(scr_pkg::F_BASE) + scr_pkg::F_W'(in_ctx.item.bounce_b);
      for (int i = 0; i < 3; i++) begin
         n[i]       = $signed(in_nrm[i]);
         prod_in[i] = n[i] * $signed({1'b0, in_ctx.pen});
         nfa_in[i]  = n[i] * $signed({1'b0, fa});
         nfb_in[i]  = n[i] * $signed({1'b0, fb});
         vpa_in[i]  = scr_pkg::comp_get(in_ctx.item.vel_a, i) * n[i];
         vpb_in[i]  = scr_pkg::comp_get(in_ctx.item.vel_b, i) * n[i];
      end
   end

   // stage 2: velocity along the normal, rounded displacements
   always_comb begin
      dot_a = scr_pkg::DOT_W'(vpa_ff[0]) + scr_pkg::DOT_W'(vpa_ff[1])
            + scr_pkg::DOT_W'(vpa_ff[2]);
      dot_b = scr_pkg::DOT_W'(vpb_ff[0]) + scr_pkg::DOT_W'(vpb_ff[1])
            + scr_pkg::DOT_W'(vpb_ff[2]);
      vna_in = scr_pkg::VN_W'(scr_pkg::shr_round(64'(dot_a), scr_pkg::VN_SHIFT));
      vnb_in = scr_pkg::VN_W'(scr_pkg::shr_round(64'(dot_b), scr_pkg::VN_SHIFT));
      for (int i = 0; i < 3; i++) begin
         dispa_in[i] = scr_pkg::DISP_W'(scr_pkg::shr_round(64'(prod_ff[i]),
            ctx1_ff.item.static_b ? scr_pkg::DISP_FULL : scr_pkg::DISP_HALF));
         dispb_in[i] = scr_pkg::DISP_W'(scr_pkg::shr_round(64'(prod_ff[i]),
            ctx1_ff.item.static_a ? scr_pkg::DISP_FULL : scr_pkg::DISP_HALF));
      end
   end

   // stage 3: new positions, velocity corrections
   always_comb begin
      move_a2 = ctx2_ff.hit && !ctx2_ff.item.static_a;
      move_b2 = ctx2_ff.hit && !ctx2_ff.item.static_b;
      posa_in = '0;
      posb_in = '0;
      for (int i = 0; i < 3; i++) begin
         posa_in[i*scr_pkg::CW +: scr_pkg::CW] = move_a2
            ? scr_pkg::sat_comp(64'(scr_pkg::comp_get(ctx2_ff.item.pos_a, i)) + 64'(dispa_ff[i]))
            : scr_pkg::comp_get(ctx2_ff.item.pos_a, i);
         posb_in[i*scr_pkg::CW +: scr_pkg::CW] = move_b2
            ? scr_pkg::sat_comp(64'(scr_pkg::comp_get(ctx2_ff.item.pos_b, i)) - 64'(dispb_ff[i]))
            : scr_pkg::comp_get(ctx2_ff.item.pos_b, i);
         corra_in[i] = nfa2_ff[i] * vna_ff;
         corrb_in[i] = nfb2_ff[i] * vnb_ff;
      end
   end

   // stage 4: bounced velocities and flags
   always_comb begin
      move_a3 = ctx3_ff.hit && !ctx3_ff.item.static_a;
      move_b3 = ctx3_ff.hit && !ctx3_ff.item.static_b;
      dy      = $signed(ctx3_ff.d[1]);
      item_in = '0;
      item_in.new_pos_a = posa_ff;
      item_in.new_pos_b = posb_ff;
      for (int i = 0; i < 3; i++) begin
         item_in.new_vel_a[i*scr_pkg::CW +: scr_pkg::CW] = move_a3
            ? scr_pkg::sat_comp(64'(scr_pkg::comp_get(ctx3_ff.item.vel_a, i))
                - scr_pkg::shr_round(64'(corra_ff[i]), scr_pkg::CORR_SHIFT))
            : scr_pkg::comp_get(ctx3_ff.item.vel_a, i);
         item_in.new_vel_b[i*scr_pkg::CW +: scr_pkg::CW] = move_b3
            ? scr_pkg::sat_comp(64'(scr_pkg::comp_get(ctx3_ff.item.vel_b, i))
                - scr_pkg::shr_round(64'(corrb_ff[i]), scr_pkg::CORR_SHIFT))
            : scr_pkg::comp_get(ctx3_ff.item.vel_b, i);
      end
      item_in.collided = ctx3_ff.hit;
      item_in.ground_a = ctx3_ff.hit && ((dy > 0) || ctx3_ff.zero);
      item_in.ground_b = ctx3_ff.hit && !ctx3_ff.zero && (dy < 0);
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      ctx1_ff <= in_ctx;
      ctx2_ff <= ctx1_ff;
      ctx3_ff <= ctx2_ff;
      for (int i = 0; i < 3; i++) begin
         prod_ff[i]  <= prod_in[i];
         nfa1_ff[i]  <= nfa_in[i];
         nfb1_ff[i]  <= nfb_in[i];
         vpa_ff[i]   <= vpa_in[i];
         vpb_ff[i]   <= vpb_in[i];
         nfa2_ff[i]  <= nfa1_ff[i];
         nfb2_ff[i]  <= nfb1_ff[i];
         dispa_ff[i] <= dispa_in[i];
         dispb_ff[i] <= dispb_in[i];
         corra_ff[i] <= corra_in[i];
         corrb_ff[i] <= corrb_in[i];
      end
      vna_ff  <= vna_in;
      vnb_ff  <= vnb_in;
      posa_ff <= posa_in;
      posb_ff <= posb_in;
      item_ff <= item_in;
   end

   assign out_valid = v4_ff;
   assign out_item  = item_ff;

endmodule

[hdl/sphere_collision_response_top.sv]
// Top level of the sphere-sphere collision response pipeline
//
// Usage: drive a sphere pair on req_item and raise start; the transaction is
// taken at a rising edge where start is high and busy is low. busy is high
// only during and right after reset, so one pair can be taken every cycle.
// Each transaction yields exactly one result on rsp_item, flagged by a
// one-cycle rsp_valid strobe, in the order the pairs came in.
// The path holds 56 register stages: 3 front stages for the input register,
// the differences and squares, and the squared distance; 30 for the square
// root, whose input stage also takes the overlap test and whose later stages
// decide one result bit each; 19 for the three normal dividers, one quotient
// bit per stage between their numerator and output stages; 4 for separation
// and bounce. Throughput: one transaction per clock cycle while busy is low.
// Reset: synchronous, active high; it clears every valid bit, so nothing in
// flight comes out. The receiver cannot stall: a result is on the port for
// its single strobe cycle only.
`include "sphere_collision_response_top_macros.svh"

module sphere_collision_response_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  scr_pkg::req_type  req_item,
   output logic              rsp_valid,
   output scr_pkg::rsp_type  rsp_item
);

   logic                               busy_ff;
   logic                               accept;
   logic                               s0_valid_ff, s1_valid_ff, s2_valid_ff;
   scr_pkg::req_type                   s0_item_ff;
   scr_pkg::ctx_type                   ctx1_in, s1_ctx_ff, s2_ctx_ff, hit_ctx;
   logic signed [scr_pkg::D_W-1:0]     d_s1   [3];
   logic [scr_pkg::SQ_W-1:0]           sq_in  [3];
   logic [scr_pkg::SQ_W-1:0]           s1_sq_ff [3];
   logic [scr_pkg::DIST2_W-1:0]        dist2_in, s2_dist2_ff;
   logic [scr_pkg::RSQ_W-1:0]          rsq_in, s2_rsq_ff;
   logic [scr_pkg::CMP_W-1:0]          dist_cmp;
   logic [scr_pkg::X_W-1:0]            iq_x;

   logic                               sq_valid;
   logic [scr_pkg::ROOT_W-1:0]         sq_root;
   scr_pkg::ctx_type                   sq_ctx;
   logic                               dv_valid;
   scr_pkg::ctx_type                   dv_ctx;
   scr_pkg::norm_type                  dv_nrm;

   // busy only around reset
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   assign busy   = busy_ff;
   assign accept = start && !busy_ff;

   // stage 1: center differences, squares, radius sum
   always_comb begin
      ctx1_in      = '0;
      ctx1_in.item = s0_item_ff;
      ctx1_in.rsum = scr_pkg::RSUM_W'(s0_item_ff.radius_a) + scr_pkg::RSUM_W'(s0_item_ff.radius_b);
      for (int i = 0; i < 3; i++) begin
         d_s1[i] = scr_pkg::D_W'(scr_pkg::comp_get(s0_item_ff.pos_a, i))
                 - scr_pkg::D_W'(scr_pkg::comp_get(s0_item_ff.pos_b, i));
         sq_in[i]      = d_s1[i] * d_s1[i];
         ctx1_in.d[i]  = d_s1[i];
      end
   end

   // stage 2: squared distance and squared radius sum
   always_comb begin
      dist2_in = scr_pkg::DIST2_W'(s1_sq_ff[0]) + scr_pkg::DIST2_W'(s1_sq_ff[1])
               + scr_pkg::DIST2_W'(s1_sq_ff[2]);
      rsq_in   = s1_ctx_ff.rsum * s1_ctx_ff.rsum;
   end

   // overlap test and root radicand
   always_comb begin
      dist_cmp    = scr_pkg::CMP_W'(s2_dist2_ff);
      hit_ctx     = s2_ctx_ff;
      hit_ctx.hit = s2_ctx_ff.item.enabled_a && s2_ctx_ff.item.enabled_b
                 && (dist_cmp <= scr_pkg::CMP_W'(s2_rsq_ff));
      iq_x        = {dist_cmp[scr_pkg::RSQ_W-1:0], {scr_pkg::FRAC_EXT{1'b0}}};
   end

   // front valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= accept;
         s1_valid_ff <= s0_valid_ff;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   // front payload
   always_ff @(posedge clock) begin
      if (accept) begin
         s0_item_ff <= req_item;
      end
      s1_ctx_ff   <= ctx1_in;
      for (int i = 0; i < 3; i++) s1_sq_ff[i] <= sq_in[i];
      s2_ctx_ff   <= s1_ctx_ff;
      s2_dist2_ff <= dist2_in;
      s2_rsq_ff   <= rsq_in;
   end

   scr_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid_ff),
      .in_x      (iq_x),
      .in_ctx    (hit_ctx),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_ctx   (sq_ctx)
   );

   scr_ndiv u_ndiv (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq_valid),
      .in_root   (sq_root),
      .in_ctx    (sq_ctx),
      .out_valid (dv_valid),
      .out_ctx   (dv_ctx),
      .out_nrm   (dv_nrm)
   );

   scr_resp u_resp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dv_valid),
      .in_ctx    (dv_ctx),
      .in_nrm    (dv_nrm),
      .out_valid (rsp_valid),
      .out_item  (rsp_item)
   );

   // checks
   `SCR_ASSERT_IMPL(a_rsp_follows_req, rsp_valid, $past(start && !busy, scr_pkg::LATENCY))
   `SCR_ASSERT_NEVER(a_ground_exclusive, rsp_valid && rsp_item.ground_a && rsp_item.ground_b)
   `SCR_ASSERT_IMPL(a_ground_needs_hit, rsp_valid && !rsp_item.collided, !rsp_item.ground_a && !rsp_item.ground_b)

endmodule
